FILE: rtl/core/car_pkg.sv
// Package for the CAN alias reservation block.
// Holds request/response payload types, phase encoding and frame codes.
// No dependencies.
package car_pkg;

   // Request function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_RX    = 2'd2;

   // Received frame kinds
   localparam logic [1:0] RX_CHECK = 2'd0;

   // Frame kinds to send
   localparam logic [1:0] FRAME_NONE    = 2'd0;
   localparam logic [1:0] FRAME_CHECK   = 2'd1;
   localparam logic [1:0] FRAME_RESERVE = 2'd2;
   localparam logic [1:0] FRAME_INIT    = 2'd3;

   // Generator constants
   localparam logic [23:0] GEN_ADD_LOW  = 24'h7A4BA9;
   localparam logic [23:0] GEN_ADD_HIGH = 24'h1B0CA3;

   localparam logic [15:0] CONFIRM_WAIT_RESET = 16'd200;

   // Sequence phases: four check frames, arm timer, wait/reserve, init, idle
   typedef enum logic [2:0] {
      PH_CHECK0 = 3'd0,
      PH_CHECK1 = 3'd1,
      PH_CHECK2 = 3'd2,
      PH_CHECK3 = 3'd3,
      PH_ARM    = 3'd4,
      PH_WAIT   = 3'd5,
      PH_INIT   = 3'd6,
      PH_IDLE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [47:0] node_id;
      logic [31:0] now_ms;
      logic        tx_free;
      logic [11:0] rx_source_alias;
      logic [1:0]  rx_kind;
   } car_req_type;

   typedef struct packed {
      logic        accepted;
      logic [1:0]  frame_kind;
      logic [1:0]  check_index;
      logic [11:0] id_fragment;
      logic [11:0] alias_out;
      logic [47:0] id_out;
      logic        reserved_done;
   } car_rsp_type;

endpackage

FILE: rtl/core/can_alias_reservation_top.sv
// Top level of the CAN alias reservation block.
// Depends on car_pkg for payload types, phase encoding and codes.
//
// Reserves a 12-bit CAN alias for a 48-bit node ID. A start request seeds
// the alias generator from the node ID; poll requests step through four
// check frames, a timed wait of confirm_wait_ms, a reserve frame and an
// init-complete frame; received-frame requests handle alias collisions.
// Every request gives exactly one response. A request is latched into an
// input register, processed against the block state and the response
// lands in an output register, so one request per clock is sustained
// while rsp_ready does not hold back the output register.
// The confirm_wait_ms register is written through the csr_ port, which is
// always ready, and should only be written while the block is idle.
module can_alias_reservation_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  car_pkg::car_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output car_pkg::car_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);
   import car_pkg::*;

   logic        req_valid_ff;
   car_req_type req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   car_rsp_type rsp_ff, rsp_in;

   logic [15:0] confirm_wait_ff;
   phase_type   phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic [23:0] gen_high_ff, gen_high_in;
   logic [23:0] gen_low_ff, gen_low_in;
   logic [47:0] held_id_ff, held_id_in;
   logic [31:0] wait_start_ff, wait_start_in;

   logic        advance;
   logic [11:0] cur_alias;
   logic [25:0] adv_low;
   logic [23:0] adv_high;
   logic [31:0] elapsed;

   // Handshakes: the stage moves when the output register can take a result
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Current alias: XOR fold of both generator halves
   assign cur_alias = gen_high_ff[11:0] ^ gen_high_ff[23:12]
                    ^ gen_low_ff[11:0] ^ gen_low_ff[23:12];

   // Generator step; low-half carry is added into the high half
   assign adv_low  = {2'b00, gen_low_ff} + {2'b00, gen_low_ff[14:0], 9'd0}
                   + {2'b00, GEN_ADD_LOW};
   assign adv_high = gen_high_ff + {gen_high_ff[14:0], gen_low_ff[23:15]}
                   + GEN_ADD_HIGH + {22'd0, adv_low[25:24]};

   assign elapsed = req_ff.now_ms - wait_start_ff;

   // Per-request step
   always_comb begin
      phase_in      = phase_ff;
      busy_in       = busy_ff;
      gen_high_in   = gen_high_ff;
      gen_low_in    = gen_low_ff;
      held_id_in    = held_id_ff;
      wait_start_in = wait_start_ff;
      rsp_in        = '0;
      rsp_in.accepted = 1'b1;

      case (req_ff.func)
         FUNC_START: begin
            if (busy_ff) begin
               rsp_in.accepted = 1'b0;
            end else begin
               busy_in     = 1'b1;
               held_id_in  = req_ff.node_id;
               gen_high_in = req_ff.node_id[47:24];
               gen_low_in  = req_ff.node_id[23:0];
               phase_in    = PH_CHECK0;
            end
         end
         FUNC_POLL: begin
            case (phase_ff)
               PH_CHECK0, PH_CHECK1, PH_CHECK2, PH_CHECK3: begin
                  if (req_ff.tx_free) begin
                     rsp_in.frame_kind  = FRAME_CHECK;
                     rsp_in.check_index = phase_ff[1:0];
                     case (phase_ff[1:0])
                        2'd0:    rsp_in.id_fragment = held_id_ff[47:36];
                        2'd1:    rsp_in.id_fragment = held_id_ff[35:24];
                        2'd2:    rsp_in.id_fragment = held_id_ff[23:12];
                        default: rsp_in.id_fragment = held_id_ff[11:0];
                     endcase
                     phase_in = phase_type'(phase_ff + 3'd1);
                  end
               end
               PH_ARM: begin
                  wait_start_in = req_ff.now_ms;
                  phase_in      = PH_WAIT;
               end
               PH_WAIT: begin
                  if (elapsed > {16'd0, confirm_wait_ff} && req_ff.tx_free) begin
                     rsp_in.frame_kind = FRAME_RESERVE;
                     phase_in          = PH_INIT;
                  end
               end
               PH_INIT: begin
                  if (req_ff.tx_free) begin
                     rsp_in.frame_kind = FRAME_INIT;
                     rsp_in.id_out     = held_id_ff;
                     phase_in          = PH_IDLE;
                     busy_in           = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_RX: begin
            // Collision on our alias: answer a check, else pick a new alias
            if (busy_ff && req_ff.rx_source_alias == cur_alias) begin
               if (req_ff.rx_kind == RX_CHECK) begin
                  rsp_in.frame_kind = FRAME_RESERVE;
               end else begin
                  gen_high_in = adv_high;
                  gen_low_in  = adv_low[23:0];
                  phase_in    = PH_CHECK0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.alias_out = gen_high_in[11:0] ^ gen_high_in[23:12]
                       ^ gen_low_in[11:0] ^ gen_low_in[23:12];
      rsp_in.reserved_done = (phase_in == PH_IDLE) && !busy_in;
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Block state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_wait_ff <= CONFIRM_WAIT_RESET;
         phase_ff        <= PH_IDLE;
         busy_ff         <= 1'b0;
         gen_high_ff     <= '0;
         gen_low_ff      <= '0;
         held_id_ff      <= '0;
         wait_start_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            confirm_wait_ff <= csr_data;
         end
         if (advance) begin
            phase_ff      <= phase_in;
            busy_ff       <= busy_in;
            gen_high_ff   <= gen_high_in;
            gen_low_ff    <= gen_low_in;
            held_id_ff    <= held_id_in;
            wait_start_ff <= wait_start_in;
         end
      end
   end

endmodule
